[src/imu_dead_reckoning_odometer_macros.svh]
// ----------------------------------------------------------------------------
// IMU dead-reckoning odometer assertion macros
// Shared property forms for the odometer checks, clocked on clk and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef IMU_DEAD_RECKONING_ODOMETER_MACROS_SVH
`define IMU_DEAD_RECKONING_ODOMETER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ODO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odometer port check failed");

// The consequent must hold in the cycle after the antecedent.
`define ODO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odometer port check failed");

`endif

[src/imudr_pkg.sv]
// ----------------------------------------------------------------------------
// IMU dead-reckoning odometer package
// Shared types, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package imudr_pkg;

  // Longest recording; the sample at index MAX_SAMPLES-1 ends it.
  localparam int MAX_SAMPLES = 32768;
  localparam int LIMIT       = (MAX_SAMPLES > 65536) ? 65536 : MAX_SAMPLES;
  localparam logic [15:0] LAST_INDEX = 16'(LIMIT - 1);

  localparam logic [15:0] TIME_STEP_RESET      = 16'd3277;
  localparam logic [7:0]  SEGMENT_LENGTH_RESET = 8'd20;

  // Configuration register indexes.
  localparam logic REG_TIME_STEP      = 1'b0;
  localparam logic REG_SEGMENT_LENGTH = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul_acc;
    logic       upd_vel;
    logic       mul_vel;
    logic       upd_dist;
    logic       div_init_mod;
    logic       div_init_avg;
    logic       div_step;
    logic       sq_step;
    logic [2:0] sq_idx;
    logic       rt_init;
    logic       rt_step;
    logic       mag_sel;     // 0: velocity, 1: distance
    logic       mag_commit;
    logic       seg_commit;
    logic       idx_inc;
    logic       fire;
  } cmd_t;

  typedef struct packed {
    logic boundary;
    logic last;
  } status_t;

  // Clamp a 50-bit signed value to the signed 48-bit range.
  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if ((v[49] == v[48]) && (v[48] == v[47])) r = v[47:0];
    else if (v[49]) r = {1'b1, 47'd0};
    else r = {1'b0, {47{1'b1}}};
    return r;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  // 24 fraction bits down to Q16.16, saturating.
  function automatic logic [31:0] to_q16(input logic [47:0] v);
    return (v[47:40] != 8'd0) ? {32{1'b1}} : v[39:8];
  endfunction

endpackage

[src/imu_dead_reckoning_odometer.sv]
// ----------------------------------------------------------------------------
// IMU dead-reckoning odometer
// Double integration of planar acceleration into segment distances and speeds.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Handshake
//  input     in_accel_x, in_accel_y, in_last_sample  start high while busy low
//  result    out_total_distance, out_average_speed,  out_valid, one cycle
//            out_segments_seen
//  config    cfg_index, cfg_data                     cfg_we, no wait
//
// A sample that ends no segment keeps busy high through the two integration
// steps, the 16-step remainder check on the sample index in the shared
// divider and the boundary decision. A segment end adds two squaring passes,
// two square roots, the two magnitude commits and the segment commit; the
// last sample adds the 48-step average speed division, and the result follows
// on the first idle cycle. One sample is in flight at a time; busy covers it.
// Reset is synchronous and active low; it restores the default time step and
// segment length and clears all integrators, sums and counters. The result
// is driven for exactly one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module imu_dead_reckoning_odometer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic               in_last_sample,
  output logic               out_valid,
  output logic [31:0]        out_total_distance,
  output logic [31:0]        out_average_speed,
  output logic [15:0]        out_segments_seen,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import imudr_pkg::*;

  // The controller and the datapath talk only through these two groups.
  cmd_t    cmd;
  status_t st;

  // Start is taken only while idle, so a transfer lands with the sequencer
  // at rest and all integrator state stable.
  imudr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // The datapath owns the configuration registers, the two integrators per
  // axis, the shared divider, the squaring multiplier and the root unit.
  imudr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_accel_x         (in_accel_x),
    .in_accel_y         (in_accel_y),
    .in_last_sample     (in_last_sample),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_total_distance (out_total_distance),
    .out_average_speed  (out_average_speed),
    .out_segments_seen  (out_segments_seen)
  );

endmodule

[src/imudr_ctrl.sv]
// ----------------------------------------------------------------------------
// IMU dead-reckoning odometer controller
// Sequences integration, segment check, magnitudes and the final average.
// ----------------------------------------------------------------------------
module imudr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  imudr_pkg::status_t st,
  output imudr_pkg::cmd_t    cmd
);
  import imudr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_VEL  = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_DIST = 4'd4;
  localparam logic [3:0] S_MOD  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_RT   = 4'd8;
  localparam logic [3:0] S_CMT  = 4'd9;
  localparam logic [3:0] S_SEG  = 4'd10;
  localparam logic [3:0] S_DIVI = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam logic [5:0] MOD_STEPS  = 6'd16;
  localparam logic [5:0] DIV_STEPS  = 6'd48;
  localparam logic [5:0] SQ_LAST    = 6'd6;
  localparam logic [5:0] SQRT_STEPS = 6'd48;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       sel_r, sel_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.mag_sel = sel_r;
    cmd.sq_idx  = cnt_r[2:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_acc = 1'b1;
        state_nxt   = S_VEL;
      end
      S_VEL: begin
        cmd.upd_vel = 1'b1;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_vel = 1'b1;
        state_nxt   = S_DIST;
      end
      S_DIST: begin
        cmd.upd_dist     = 1'b1;
        cmd.div_init_mod = 1'b1;
        cnt_nxt          = '0;
        state_nxt        = S_MOD;
      end
      S_MOD: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == MOD_STEPS - 6'd1) state_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt = '0;
        sel_nxt = 1'b0;
        if (st.boundary) begin
          state_nxt = S_SQ;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_RT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_RT: begin
        if (cnt_r == 6'd0) cmd.rt_init = 1'b1;
        else cmd.rt_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == SQRT_STEPS) state_nxt = S_CMT;
      end
      S_CMT: begin
        cmd.mag_commit = 1'b1;
        cnt_nxt        = '0;
        if (sel_r) begin
          state_nxt = S_SEG;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SEG: begin
        cmd.seg_commit = 1'b1;
        if (st.last) begin
          state_nxt = S_DIVI;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_DIVI: begin
        cmd.div_init_avg = 1'b1;
        cnt_nxt          = '0;
        state_nxt        = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == DIV_STEPS - 6'd1) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.fire  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

[src/imudr_dp.sv]
// ----------------------------------------------------------------------------
// IMU dead-reckoning odometer datapath
// Integrators, shared divider, squaring multiplier and square-root unit.
// ----------------------------------------------------------------------------
module imudr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  imudr_pkg::cmd_t    cmd,
  output imudr_pkg::status_t st,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic               in_last_sample,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  output logic [31:0]        out_total_distance,
  output logic [31:0]        out_average_speed,
  output logic [15:0]        out_segments_seen
);
  import imudr_pkg::*;

  // Configuration.
  logic [15:0] ts_r;
  logic [7:0]  sl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TIME_STEP_RESET;
      sl_r <= SEGMENT_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:      ts_r <= cfg_data;
        REG_SEGMENT_LENGTH: sl_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sample registers and integrators.
  logic signed [15:0] ax_r, ay_r;
  logic               last_r;
  logic signed [32:0] pa_x_r, pa_y_r;
  logic signed [64:0] pv_x_r, pv_y_r;
  logic signed [47:0] vx_r, vy_r, dx_r, dy_r;
  logic [47:0]        spd_sum_r, dst_sum_r;
  logic [15:0]        idx_r, seg_cnt_r;

  logic signed [16:0] dt_s;
  logic signed [32:0] pa_x_nxt, pa_y_nxt;
  logic signed [64:0] pv_x_nxt, pv_y_nxt;
  logic signed [49:0] vx_sum, vy_sum, dx_sum, dy_sum;

  assign dt_s     = $signed({1'b0, ts_r});
  assign pa_x_nxt = ax_r * dt_s;
  assign pa_y_nxt = ay_r * dt_s;
  assign pv_x_nxt = vx_r * dt_s;
  assign pv_y_nxt = vy_r * dt_s;
  assign vx_sum   = {{2{vx_r[47]}}, vx_r} + {{17{pa_x_r[32]}}, pa_x_r};
  assign vy_sum   = {{2{vy_r[47]}}, vy_r} + {{17{pa_y_r[32]}}, pa_y_r};
  // Floor shift by 16 of the velocity product.
  assign dx_sum   = {{2{dx_r[47]}}, dx_r} + {pv_x_r[64], pv_x_r[64:16]};
  assign dy_sum   = {{2{dy_r[47]}}, dy_r} + {pv_y_r[64], pv_y_r[64:16]};

  // Shared restoring divider: segment position check and final average.
  logic [47:0] dvd_r;
  logic [15:0] rem_r, dsr_r;
  logic [16:0] rem_t;
  logic        rem_ge;

  assign rem_t  = {rem_r, dvd_r[47]};
  assign rem_ge = (rem_t >= {1'b0, dsr_r});

  // Squaring: 24x24 partial products summed into a 96-bit radicand.
  logic [47:0] comp_u;
  logic signed [47:0] comp_s;
  logic [23:0] mul_a, mul_b;
  logic [47:0] p_r;
  logic [1:0]  part_r, part;
  logic [95:0] n_r, p_shift;

  always_comb begin
    if (cmd.mag_sel) comp_s = (cmd.sq_idx < 3'd3) ? dx_r : dy_r;
    else comp_s = (cmd.sq_idx < 3'd3) ? vx_r : vy_r;
    comp_u = comp_s[47] ? 48'(-comp_s) : 48'(comp_s);
    case (cmd.sq_idx)
      3'd0, 3'd3: part = 2'd0;
      3'd1, 3'd4: part = 2'd1;
      default:    part = 2'd2;
    endcase
    mul_a = (part == 2'd2) ? comp_u[23:0] : comp_u[47:24];
    mul_b = (part == 2'd0) ? comp_u[47:24] : comp_u[23:0];
    case (part_r)
      2'd0:    p_shift = {p_r, 48'd0};
      2'd1:    p_shift = {23'd0, p_r, 25'd0};
      default: p_shift = {48'd0, p_r};
    endcase
  end

  // Digit-by-digit square root, one result bit per step.
  logic [95:0] rad_r;
  logic [47:0] root_r;
  logic [49:0] rrem_r;
  logic [51:0] rrem_t, trial;
  logic        rt_ge;

  assign rrem_t = {rrem_r, rad_r[95:94]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign rt_ge  = (rrem_t >= trial);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r   <= in_accel_x;
      ay_r   <= in_accel_y;
      last_r <= in_last_sample || (idx_r >= LAST_INDEX);
    end
    if (cmd.mul_acc) begin
      pa_x_r <= pa_x_nxt;
      pa_y_r <= pa_y_nxt;
    end
    if (cmd.mul_vel) begin
      pv_x_r <= pv_x_nxt;
      pv_y_r <= pv_y_nxt;
    end
    if (cmd.div_init_mod) begin
      dvd_r <= {idx_r, 32'd0};
      rem_r <= '0;
      dsr_r <= (sl_r == 8'd0) ? 16'd1 : {8'd0, sl_r};
    end else if (cmd.div_init_avg) begin
      dvd_r <= spd_sum_r;
      rem_r <= '0;
      dsr_r <= seg_cnt_r;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[46:0], rem_ge};
      rem_r <= rem_ge ? 16'(rem_t - {1'b0, dsr_r}) : rem_t[15:0];
    end
    if (cmd.sq_step) begin
      p_r    <= 48'(mul_a) * 48'(mul_b);
      part_r <= part;
      n_r    <= (cmd.sq_idx == 3'd0) ? 96'd0 : n_r + p_shift;
    end
    if (cmd.rt_init) begin
      rad_r  <= n_r;
      root_r <= '0;
      rrem_r <= '0;
    end else if (cmd.rt_step) begin
      rad_r  <= {rad_r[93:0], 2'b00};
      root_r <= {root_r[46:0], rt_ge};
      rrem_r <= rt_ge ? 50'(rrem_t - trial) : rrem_t[49:0];
    end
  end

  assign st.boundary = (rem_r == 16'd0) || last_r;
  assign st.last     = last_r;

  // Architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r      <= '0;
      vy_r      <= '0;
      dx_r      <= '0;
      dy_r      <= '0;
      spd_sum_r <= '0;
      dst_sum_r <= '0;
      idx_r     <= '0;
      seg_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.fire;
      if (cmd.upd_vel) begin
        vx_r <= sat48(vx_sum);
        vy_r <= sat48(vy_sum);
      end
      if (cmd.upd_dist) begin
        dx_r <= sat48(dx_sum);
        dy_r <= sat48(dy_sum);
      end
      if (cmd.mag_commit) begin
        if (cmd.mag_sel) dst_sum_r <= sat_add48(dst_sum_r, root_r);
        else spd_sum_r <= sat_add48(spd_sum_r, root_r);
      end
      if (cmd.seg_commit) begin
        if (seg_cnt_r != 16'hFFFF) seg_cnt_r <= seg_cnt_r + 16'd1;
        vx_r <= '0;
        vy_r <= '0;
        dx_r <= '0;
        dy_r <= '0;
      end
      if (cmd.idx_inc) idx_r <= idx_r + 16'd1;
      if (cmd.fire) begin
        spd_sum_r <= '0;
        dst_sum_r <= '0;
        idx_r     <= '0;
        seg_cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      out_total_distance <= to_q16(dst_sum_r);
      out_average_speed  <= to_q16(dvd_r);
      out_segments_seen  <= seg_cnt_r;
    end
  end

endmodule

[src/imudr_checker.sv]
// ----------------------------------------------------------------------------
// IMU dead-reckoning odometer checker
// Port-level checks on the odometer, bound to the top level.
// ----------------------------------------------------------------------------
`include "imu_dead_reckoning_odometer_macros.svh"

module imudr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [15:0] out_segments_seen
);

  // An accepted sample keeps the block busy for the following cycle.
  `ODO_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // A result strobe lasts a single cycle.
  `ODO_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  // The result appears once the sequencer has returned to rest.
  `ODO_ASSERT_NOW(a_result_idle, out_valid, !busy)
  // The final sample always closes a segment, so the count is never zero.
  `ODO_ASSERT_NOW(a_seg_nonzero, out_valid, out_segments_seen != 16'd0)

endmodule

bind imu_dead_reckoning_odometer imudr_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_segments_seen (out_segments_seen)
);
